/* src/gtti_pkg.sv */
// Shared types and constants for the gyro rate to turn integrator.
package gtti_pkg;

	// Field and state widths
	localparam int TIME_W     = 64;
	localparam int RATE_W     = 32;
	localparam int REM_W      = 40;
	localparam int OUT_W      = 24;
	localparam int SENS_W     = 8;
	localparam int ALPHA_W    = 17;
	localparam int MAXI_W     = 20;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;

	// Shared multiplier: signed operands, full-width product
	localparam int MUL_W  = 34;
	localparam int PROD_W = 2 * MUL_W;

	// 10430.378 * 1.5 / 50 / 1e6 in units of 2^-32
	localparam int COEF_W = 21;
	localparam logic [COEF_W-1:0] TURN_COEF = 21'd1343944;

	// Saturation limits
	localparam logic signed [RATE_W-1:0] RATE_MAX = {1'b0, {(RATE_W-1){1'b1}}};
	localparam logic signed [RATE_W-1:0] RATE_MIN = {1'b1, {(RATE_W-1){1'b0}}};
	localparam logic signed [REM_W-1:0]  REM_MAX  = {1'b0, {(REM_W-1){1'b1}}};
	localparam logic signed [REM_W-1:0]  REM_MIN  = {1'b1, {(REM_W-1){1'b0}}};
	localparam logic signed [OUT_W-1:0]  OUT_MAX  = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0]  OUT_MIN  = {1'b1, {(OUT_W-1){1'b0}}};

	// Integer-part magnitude is compared at this width
	localparam int IPX_W = 33;
	localparam logic [IPX_W-1:0] POS_LIM = IPX_W'((64'd1 << (OUT_W-1)) - 64'd1);
	localparam logic [IPX_W-1:0] NEG_LIM = IPX_W'(64'd1 << (OUT_W-1));

	// Register reset values
	localparam logic [SENS_W-1:0]  SENS_RST  = 8'd50;
	localparam logic [ALPHA_W-1:0] ALPHA_RST = 17'd22938;
	localparam logic [MAXI_W-1:0]  MAXI_RST  = 20'd100000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SENS  = 2'd0,
		CFG_ALPHA = 2'd1,
		CFG_MAXI  = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [SENS_W-1:0]  sens;
		logic [ALPHA_W-1:0] alpha;
		logic [MAXI_W-1:0]  max_interval;
	} cfg_t;

endpackage

/* src/gtti_cfg.sv */
// Configuration register file: sensitivity, filter coefficient and gap limit.
module gtti_cfg import gtti_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	// Always able to take a write transfer
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sens         <= SENS_RST;
			cfg_q.alpha        <= ALPHA_RST;
			cfg_q.max_interval <= MAXI_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SENS:  cfg_q.sens         <= cfg_data[SENS_W-1:0];
				CFG_ALPHA: cfg_q.alpha        <= cfg_data[ALPHA_W-1:0];
				CFG_MAXI:  cfg_q.max_interval <= cfg_data[MAXI_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

/* src/gtti_mul.sv */
// Shared signed multiplier with registered product.
module gtti_mul import gtti_pkg::*; (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [MUL_W-1:0]  a,
	input  logic signed [MUL_W-1:0]  b,
	output logic signed [PROD_W-1:0] prod_q
);

	// One product per cycle, held until the next enabled cycle
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= a * b;
		end
	end

endmodule

/* src/gyro_rate_to_turn_integrator_core.sv */
// Top level: sequencer and datapath of the gyro rate to turn integrator.
//
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------------------
//  in      | in_valid / in_ready   | active, sample_ok, host_time_us, device_time_us,
//          |                       | yaw_rate
//  out     | out_valid / out_ready | turn_amount
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Integrated samples pass check, EMA, filter, abs, magnitude, low, high, accumulate,
// integer part and emit before in_ready returns; five passes through the single
// shared multiplier set the length. A sample dropped by the flag or time checks
// ends after check. Emit waits on an untaken output turn unless the new turn is zero.
// arst_n clears filter state and the output, and restores register defaults.
// cfg_ready is always high.
module gyro_rate_to_turn_integrator_core import gtti_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     active,
	input  logic                     sample_ok,
	input  logic [TIME_W-1:0]        host_time_us,
	input  logic [TIME_W-1:0]        device_time_us,
	input  logic signed [RATE_W-1:0] yaw_rate,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [OUT_W-1:0]  turn_amount,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data
);

	localparam int SHIFT = 48 - FRAC_BITS;
	localparam int LO_W  = 32;
	localparam int LOP_W = LO_W + COEF_W;
	localparam int HIP_W = 28 + COEF_W;
	localparam int TOT_W = LO_W + HIP_W;
	localparam int INC_W = TOT_W - SHIFT;
	localparam int SUM_W = INC_W + 2;
	localparam int DIFF_W = RATE_W + 1;
	localparam int RSUM_W = RATE_W + 3;

	typedef enum logic [10:0] {
		S_IDLE  = 11'b000_0000_0001,
		S_CHECK = 11'b000_0000_0010,
		S_EMA   = 11'b000_0000_0100,
		S_FILT  = 11'b000_0000_1000,
		S_ABS   = 11'b000_0001_0000,
		S_MAG   = 11'b000_0010_0000,
		S_LO    = 11'b000_0100_0000,
		S_HI    = 11'b000_1000_0000,
		S_ACC   = 11'b001_0000_0000,
		S_IPART = 11'b010_0000_0000,
		S_EMIT  = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;
	cfg_t   cfg;

	// Architectural state
	logic [TIME_W-1:0]        last_q;
	logic signed [RATE_W-1:0] f_q;
	logic signed [REM_W-1:0]  rem_q;

	// Per-sample working registers
	logic [TIME_W-1:0]        t_q;
	logic                     ok_q;
	logic signed [RATE_W-1:0] y_q;
	logic [MAXI_W-1:0]        dt_q;
	logic signed [DIFF_W-1:0] diff_q;
	logic [RATE_W-1:0]        f_abs_q;
	logic                     neg_q;
	logic [27:0]              mag_hi_q;
	logic [LOP_W-1:0]         lo_q;
	logic signed [OUT_W-1:0]  ip_q;
	logic                     out_valid_q;
	logic signed [OUT_W-1:0]  turn_q;

	// Multiplier interface
	logic                     mul_en;
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod_q;

	// Combinational results
	logic [TIME_W:0]          sub;
	logic                     not_adv, too_long;
	logic signed [DIFF_W-1:0] diff_d;
	logic signed [RSUM_W-1:0] rate_sum;
	logic signed [RATE_W-1:0] rate_sat;
	logic [TOT_W-1:0]         total;
	logic [INC_W-1:0]         inc;
	logic signed [SUM_W-1:0]  sum;
	logic signed [REM_W-1:0]  rem_sat;
	logic [REM_W-1:0]         rem_mag;
	logic [IPX_W-1:0]         ip_ext;
	logic signed [OUT_W-1:0]  ip_d;
	logic                     out_free, emit_done, accept;

	gtti_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	gtti_mul u_mul (
		.clk    (clk),
		.en     (mul_en),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	assign in_ready    = (state_q == S_IDLE);
	assign accept      = in_valid && in_ready;
	assign out_valid   = out_valid_q;
	assign turn_amount = turn_q;
	assign out_free    = !out_valid_q || out_ready;
	assign emit_done   = (state_q == S_EMIT) && ((ip_q == '0) || out_free);

	// Time checks and filter difference
	always_comb begin
		sub      = {1'b0, t_q} - {1'b0, last_q};
		not_adv  = sub[TIME_W] || (sub[TIME_W-1:0] == '0);
		too_long = (sub[TIME_W-1:MAXI_W] != '0) || (sub[MAXI_W-1:0] > cfg.max_interval);
		diff_d   = DIFF_W'(y_q) - DIFF_W'(f_q);
	end

	// Operand select for the shared multiplier
	always_comb begin
		mul_en = 1'b1;
		mul_a  = '0;
		mul_b  = '0;
		case (state_q)
			S_EMA: begin
				mul_a = MUL_W'(diff_q);
				mul_b = MUL_W'(cfg.alpha);
			end
			S_FILT: begin
				mul_a = MUL_W'(dt_q);
				mul_b = MUL_W'(cfg.sens);
			end
			S_MAG: begin
				mul_a = MUL_W'(f_abs_q);
				mul_b = MUL_W'(prod_q[27:0]);
			end
			S_LO: begin
				mul_a = MUL_W'(prod_q[LO_W-1:0]);
				mul_b = MUL_W'(TURN_COEF);
			end
			S_HI: begin
				mul_a = MUL_W'(mag_hi_q);
				mul_b = MUL_W'(TURN_COEF);
			end
			default: mul_en = 1'b0;
		endcase
	end

	// EMA update: floor shift of the product, then saturate
	always_comb begin
		rate_sum = RSUM_W'(f_q) + RSUM_W'($signed(prod_q[49:16]));
		if (rate_sum > RSUM_W'(RATE_MAX)) begin
			rate_sat = RATE_MAX;
		end else if (rate_sum < RSUM_W'(RATE_MIN)) begin
			rate_sat = RATE_MIN;
		end else begin
			rate_sat = rate_sum[RATE_W-1:0];
		end
	end

	// Scaled increment into the remainder, turn opposite to the rate
	always_comb begin
		total = {prod_q[HIP_W-1:0], {LO_W{1'b0}}} + TOT_W'(lo_q);
		inc   = total[TOT_W-1:SHIFT];
		if (neg_q) begin
			sum = SUM_W'(rem_q) + $signed({2'b00, inc});
		end else begin
			sum = SUM_W'(rem_q) - $signed({2'b00, inc});
		end
		if (sum > SUM_W'(REM_MAX)) begin
			rem_sat = REM_MAX;
		end else if (sum < SUM_W'(REM_MIN)) begin
			rem_sat = REM_MIN;
		end else begin
			rem_sat = sum[REM_W-1:0];
		end
	end

	// Integer part, truncated toward zero and saturated
	always_comb begin
		rem_mag = rem_q[REM_W-1] ? REM_W'(-rem_q) : REM_W'(rem_q);
		ip_ext  = IPX_W'(rem_mag[REM_W-1:FRAC_BITS]);
		if (rem_q[REM_W-1]) begin
			ip_d = (ip_ext > NEG_LIM) ? OUT_MIN : -$signed(ip_ext[OUT_W-1:0]);
		end else begin
			ip_d = (ip_ext > POS_LIM) ? OUT_MAX : $signed(ip_ext[OUT_W-1:0]);
		end
	end

	// Sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (in_valid) state_d = S_CHECK;
			S_CHECK: begin
				if (ok_q && (last_q != '0) && !not_adv && !too_long) begin
					state_d = S_EMA;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_EMA:   state_d = S_FILT;
			S_FILT:  state_d = S_ABS;
			S_ABS:   state_d = S_MAG;
			S_MAG:   state_d = S_LO;
			S_LO:    state_d = S_HI;
			S_HI:    state_d = S_ACC;
			S_ACC:   state_d = S_IPART;
			S_IPART: state_d = S_EMIT;
			S_EMIT:  if (emit_done) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Control and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			last_q      <= '0;
			f_q         <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_CHECK: begin
					if (!ok_q || ((last_q != '0) && not_adv)) begin
						last_q <= '0;
						f_q    <= '0;
						rem_q  <= '0;
					end else begin
						last_q <= t_q;
						if ((last_q != '0) && too_long) begin
							f_q   <= '0;
							rem_q <= '0;
						end
					end
				end
				S_FILT: f_q <= rate_sat;
				S_ACC:  rem_q <= rem_sat;
				S_EMIT: begin
					if (emit_done) begin
						rem_q <= rem_q - (REM_W'(ip_q) <<< FRAC_BITS);
					end
				end
				default: ;
			endcase
			// Output register: load on emit, drop on transfer
			if (emit_done && (ip_q != '0)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			t_q  <= (host_time_us != '0) ? host_time_us : device_time_us;
			ok_q <= active && sample_ok;
			y_q  <= yaw_rate;
		end
		case (state_q)
			S_CHECK: begin
				dt_q   <= sub[MAXI_W-1:0];
				diff_q <= diff_d;
			end
			S_ABS: begin
				f_abs_q <= f_q[RATE_W-1] ? RATE_W'(-f_q) : RATE_W'(f_q);
				neg_q   <= f_q[RATE_W-1];
			end
			S_LO:    mag_hi_q <= prod_q[59:32];
			S_HI:    lo_q <= prod_q[LOP_W-1:0];
			S_IPART: ip_q <= ip_d;
			default: ;
		endcase
		if (emit_done && (ip_q != '0)) begin
			turn_q <= ip_q;
		end
	end

	// Assertions
	a_accept_to_check: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_CHECK))
		else $error("transfer not followed by time check");

	a_out_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (turn_amount != '0))
		else $error("zero turn presented");

	a_no_time_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(last_q == '0) |-> ((f_q == '0) && (rem_q == '0)))
		else $error("filter state left without a recorded time");

	a_out_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_EMIT))
		else $error("output loaded outside the emit step");

endmodule
